@@ hw/rtl/page_framebuffer_draw_engine_macros.svh @@
// Assertion helpers for the RTL of the draw engine.
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define PFDE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
`define PFDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define PFDE_ASSERT_SAME(label, clk, rst, ante, cons)
`define PFDE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/pfde_pkg.sv @@
package pfde_pkg;

   localparam int DISPLAY_WIDTH_DEFAULT  = 128;
   localparam int DISPLAY_HEIGHT_DEFAULT = 64;
   localparam int GLYPH_COLS             = 6;
   localparam int GLYPH_ROWS             = 8;

   localparam logic [2:0] OP_CLEAR = 3'd0;
   localparam logic [2:0] OP_PIXEL = 3'd1;
   localparam logic [2:0] OP_GLYPH = 3'd2;
   localparam logic [2:0] OP_LINE  = 3'd3;
   localparam logic [2:0] OP_BOX   = 3'd4;
   localparam logic [2:0] OP_READ  = 3'd5;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] x_pos;
      logic [7:0] y_pos;
      logic       pixel_on;
      logic [7:0] char_code;
      logic [7:0] span_width;
      logic [7:0] span_height;
      logic       fill_box;
      logic [9:0] read_index;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       ignored;
   } rsp_payload_type;

   // Whole 6x8 cell of a glyph, leftmost column in the top byte.
   // Codes without an entry give a blank cell.
   function automatic logic [47:0] glyph_cell(logic [7:0] code);
      logic [47:0] pattern;
      case (code)
         8'h2B: pattern = 48'h10107C101000; // plus
         8'h2D: pattern = 48'h101010101000; // minus
         8'h2E: pattern = 48'h006060000000; // period
         8'h2F: pattern = 48'h201008040200; // slash
         8'h30: pattern = 48'h3E5149453E00;
         8'h31: pattern = 48'h00427F400000;
         8'h32: pattern = 48'h426151494600;
         8'h33: pattern = 48'h2141454B3100;
         8'h34: pattern = 48'h1814127F1000;
         8'h35: pattern = 48'h274545453900;
         8'h36: pattern = 48'h3C4A49493000;
         8'h37: pattern = 48'h017109050300;
         8'h38: pattern = 48'h364949493600;
         8'h39: pattern = 48'h064949291E00;
         8'h3A: pattern = 48'h003636000000; // colon
         8'h3E: pattern = 48'h004122140800; // greater than
         8'h41: pattern = 48'h7E1111117E00;
         8'h42: pattern = 48'h7F4949493600;
         8'h43: pattern = 48'h3E4141412200;
         8'h44: pattern = 48'h7F4141221C00;
         8'h45: pattern = 48'h7F4949494100;
         8'h46: pattern = 48'h7F0909090100;
         8'h47: pattern = 48'h3E4149497A00;
         8'h48: pattern = 48'h7F0808087F00;
         8'h49: pattern = 48'h00417F410000;
         8'h4A: pattern = 48'h2040413F0100;
         8'h4B: pattern = 48'h7F0814224100;
         8'h4C: pattern = 48'h7F4040404000;
         8'h4D: pattern = 48'h7F020C027F00;
         8'h4E: pattern = 48'h7F0408107F00;
         8'h4F: pattern = 48'h3E4141413E00;
         8'h50: pattern = 48'h7F0909090600;
         8'h51: pattern = 48'h3E4151215E00;
         8'h52: pattern = 48'h7F0919294600;
         8'h53: pattern = 48'h464949493100;
         8'h54: pattern = 48'h01017F010100;
         8'h55: pattern = 48'h3F4040403F00;
         8'h56: pattern = 48'h1F2040201F00;
         8'h57: pattern = 48'h3F4038403F00;
         8'h58: pattern = 48'h631408146300;
         8'h59: pattern = 48'h070870080700;
         8'h5A: pattern = 48'h615149454300;
         8'h5F: pattern = 48'h404040404000; // underscore
         8'h61: pattern = 48'h205454547800;
         8'h62: pattern = 48'h7F4844443800;
         8'h63: pattern = 48'h384444442000;
         8'h64: pattern = 48'h384444487F00;
         8'h65: pattern = 48'h385454541800;
         8'h66: pattern = 48'h087E09010200;
         8'h67: pattern = 48'h0C5252523E00;
         8'h68: pattern = 48'h7F0804047800;
         8'h69: pattern = 48'h00447D400000;
         8'h6A: pattern = 48'h2040443D0000;
         8'h6B: pattern = 48'h7F1028440000;
         8'h6C: pattern = 48'h00417F400000;
         8'h6D: pattern = 48'h7C0418047800;
         8'h6E: pattern = 48'h7C0804047800;
         8'h6F: pattern = 48'h384444443800;
         8'h70: pattern = 48'h7C1414140800;
         8'h71: pattern = 48'h081414187C00;
         8'h72: pattern = 48'h7C0804040800;
         8'h73: pattern = 48'h485454542000;
         8'h74: pattern = 48'h043F44402000;
         8'h75: pattern = 48'h3C4040207C00;
         8'h76: pattern = 48'h1C2040201C00;
         8'h77: pattern = 48'h3C4030403C00;
         8'h78: pattern = 48'h442810284400;
         8'h79: pattern = 48'h0C5050503C00;
         8'h7A: pattern = 48'h4464544C4400;
         default: pattern = 48'h0;
      endcase
      return pattern;
   endfunction

   // One column of a glyph; bit n is row n of the cell.
   function automatic logic [7:0] glyph_column(logic [7:0] code, logic [2:0] col);
      logic [47:0] pattern;
      logic [7:0]  bits;
      pattern = glyph_cell(code);
      case (col)
         3'd0:    bits = pattern[47:40];
         3'd1:    bits = pattern[39:32];
         3'd2:    bits = pattern[31:24];
         3'd3:    bits = pattern[23:16];
         3'd4:    bits = pattern[15:8];
         3'd5:    bits = pattern[7:0];
         default: bits = 8'h00;
      endcase
      return bits;
   endfunction

endpackage

@@ hw/rtl/pfde_stream_if.sv @@
interface pfde_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/page_framebuffer_draw_engine.sv @@
// Monochrome page-format framebuffer with a 6x8 font: one request in, one response out.
// After reset the store is swept to zero, all DISPLAY_WIDTH*ceil(DISPLAY_HEIGHT/8)
// bytes (1024 at 128x64), before the first request is taken; the clear request runs
// the same sweep. All drawing goes through one read-modify-write path on the frame
// store, which has one read port and one write port: a drawn pixel is read in ST_DRAW
// and written back in ST_WRITE, and a clipped or skipped position passes ST_DRAW only.
// A glyph walks its 6x8 cell, a line its columns, and a box each of its width*height
// positions. A byte read passes ST_READ and ST_FETCH. The response is held until
// taken, and no new request is taken until then.
`include "page_framebuffer_draw_engine_macros.svh"

module page_framebuffer_draw_engine #(
   parameter int DISPLAY_WIDTH  = pfde_pkg::DISPLAY_WIDTH_DEFAULT,
   parameter int DISPLAY_HEIGHT = pfde_pkg::DISPLAY_HEIGHT_DEFAULT
) (
   input logic           clock,
   input logic           reset,
   pfde_stream_if.sink   req_chan,
   pfde_stream_if.source rsp_chan
);
   import pfde_pkg::*;

   localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
   localparam int FRAME_BYTES = DISPLAY_WIDTH * PAGE_COUNT;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int RIDX_W      = (ADDR_W > 10) ? ADDR_W : 10;

   localparam logic [7:0]        WIDTH_LIMIT  = 8'(DISPLAY_WIDTH);
   localparam logic [7:0]        HEIGHT_LIMIT = 8'(DISPLAY_HEIGHT);
   localparam logic [7:0]        GLYPH_X_MAX  = 8'(DISPLAY_WIDTH - GLYPH_COLS);
   localparam logic [7:0]        GLYPH_Y_MAX  = 8'(DISPLAY_HEIGHT - GLYPH_ROWS);
   localparam logic [7:0]        GLYPH_LAST_X = 8'(GLYPH_COLS - 1);
   localparam logic [7:0]        GLYPH_LAST_Y = 8'(GLYPH_ROWS - 1);
   localparam logic [ADDR_W-1:0] LAST_ADDR    = ADDR_W'(FRAME_BYTES - 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE   = ADDR_W'(DISPLAY_WIDTH);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DRAW,
      ST_WRITE,
      ST_READ,
      ST_FETCH,
      ST_RESP
   } state_type;

   state_type         state_ff;
   logic              clear_rsp_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   req_payload_type   req_ff;
   logic [7:0]        dx_ff;
   logic [7:0]        dy_ff;
   logic [7:0]        last_dx_ff;
   logic [7:0]        last_dy_ff;
   logic [ADDR_W-1:0] pix_addr_ff;
   logic [7:0]        mask_ff;
   logic              set_ff;
   rsp_payload_type   rsp_ff;

   logic [7:0]        frame_mem [FRAME_BYTES];
   logic [7:0]        rdata_ff;

   logic [7:0]        px;
   logic [7:0]        py;
   logic              visible;
   logic              on_edge;
   logic              wanted;
   logic [7:0]        font_col;
   logic              pix_value;
   logic [ADDR_W-1:0] pix_addr;
   logic [7:0]        pix_mask;
   logic              last_pos;
   logic [RIDX_W-1:0] ridx_wide;
   logic              ridx_in_range;
   logic [ADDR_W-1:0] rd_addr;
   logic              mem_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              req_accept;
   logic              glyph_off;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rsp_chan.valid = (state_ff == ST_RESP);
   assign rsp_chan.payload = rsp_ff;

   // A glyph that does not fit is dropped as a whole.
   assign glyph_off = (req_chan.payload.operation == OP_GLYPH) &&
                      (req_chan.payload.x_pos > GLYPH_X_MAX ||
                       req_chan.payload.y_pos > GLYPH_Y_MAX);

   // Pixel position of the current step; coordinates wrap at 256.
   assign px = req_ff.x_pos + dx_ff;
   assign py = req_ff.y_pos + dy_ff;
   assign visible = (px < WIDTH_LIMIT) && (py < HEIGHT_LIMIT);
   assign on_edge = (dx_ff == 8'd0) || (dy_ff == 8'd0) ||
                    (dx_ff == last_dx_ff) || (dy_ff == last_dy_ff);
   assign wanted = (req_ff.operation != OP_BOX) || req_ff.fill_box || on_edge;
   assign font_col = glyph_column(req_ff.char_code, dx_ff[2:0]);
   assign last_pos = (dx_ff == last_dx_ff) && (dy_ff == last_dy_ff);
   assign pix_addr = ADDR_W'(py[7:3]) * ROW_STRIDE + ADDR_W'(px);
   assign pix_mask = 8'h01 << py[2:0];

   always_comb begin
      case (req_ff.operation)
         OP_GLYPH: pix_value = font_col[dy_ff[2:0]];
         OP_PIXEL: pix_value = req_ff.pixel_on;
         default:  pix_value = 1'b1;
      endcase
   end

   assign ridx_wide = RIDX_W'(req_ff.read_index);
   assign ridx_in_range = (32'(req_ff.read_index) < FRAME_BYTES);
   assign rd_addr = (state_ff == ST_READ) ? ridx_wide[ADDR_W-1:0] : pix_addr;

   assign mem_we  = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : pix_addr_ff;
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         wr_data = 8'h00;
      end else if (set_ff) begin
         wr_data = rdata_ff | mask_ff;
      end else begin
         wr_data = rdata_ff & ~mask_ff;
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_rsp_ff <= 1'b0;
         clr_addr_ff  <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (clr_addr_ff == LAST_ADDR) begin
                  state_ff     <= clear_rsp_ff ? ST_RESP : ST_IDLE;
                  clear_rsp_ff <= 1'b0;
               end else begin
                  clr_addr_ff <= clr_addr_ff + 1'b1;
               end
            end
            ST_IDLE: begin
               if (req_accept) begin
                  req_ff <= req_chan.payload;
                  rsp_ff <= {8'h00, glyph_off};
                  dx_ff  <= 8'd0;
                  dy_ff  <= 8'd0;
                  unique case (req_chan.payload.operation)
                     OP_CLEAR: begin
                        clr_addr_ff  <= '0;
                        clear_rsp_ff <= 1'b1;
                        state_ff     <= ST_CLEAR;
                     end
                     OP_PIXEL: begin
                        last_dx_ff <= 8'd0;
                        last_dy_ff <= 8'd0;
                        state_ff   <= ST_DRAW;
                     end
                     OP_GLYPH: begin
                        last_dx_ff <= GLYPH_LAST_X;
                        last_dy_ff <= GLYPH_LAST_Y;
                        if (glyph_off) begin
                           state_ff <= ST_RESP;
                        end else begin
                           state_ff <= ST_DRAW;
                        end
                     end
                     OP_LINE: begin
                        last_dx_ff <= req_chan.payload.span_width - 8'd1;
                        last_dy_ff <= 8'd0;
                        state_ff   <= (req_chan.payload.span_width == 8'd0) ?
                                      ST_RESP : ST_DRAW;
                     end
                     OP_BOX: begin
                        last_dx_ff <= req_chan.payload.span_width - 8'd1;
                        last_dy_ff <= req_chan.payload.span_height - 8'd1;
                        state_ff   <= (req_chan.payload.span_width == 8'd0 ||
                                       req_chan.payload.span_height == 8'd0) ?
                                      ST_RESP : ST_DRAW;
                     end
                     OP_READ: begin
                        state_ff <= ST_READ;
                     end
                     default: begin
                        state_ff <= ST_RESP;
                     end
                  endcase
               end
            end
            ST_DRAW: begin
               if (visible && wanted) begin
                  pix_addr_ff <= pix_addr;
                  mask_ff     <= pix_mask;
                  set_ff      <= pix_value;
                  state_ff    <= ST_WRITE;
               end else begin
                  if (req_ff.operation == OP_PIXEL && !visible) begin
                     rsp_ff.ignored <= 1'b1;
                  end
                  if (last_pos) begin
                     state_ff <= ST_RESP;
                  end else if (dx_ff == last_dx_ff) begin
                     dx_ff <= 8'd0;
                     dy_ff <= dy_ff + 8'd1;
                  end else begin
                     dx_ff <= dx_ff + 8'd1;
                  end
               end
            end
            ST_WRITE: begin
               // The merged byte goes back this cycle; step to the next position.
               if (last_pos) begin
                  state_ff <= ST_RESP;
               end else begin
                  state_ff <= ST_DRAW;
                  if (dx_ff == last_dx_ff) begin
                     dx_ff <= 8'd0;
                     dy_ff <= dy_ff + 8'd1;
                  end else begin
                     dx_ff <= dx_ff + 8'd1;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_FETCH;
            end
            ST_FETCH: begin
               rsp_ff.read_data <= ridx_in_range ? rdata_ff : 8'h00;
               state_ff         <= ST_RESP;
            end
            ST_RESP: begin
               if (rsp_chan.ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   `PFDE_ASSERT_NEXT(busy_after_request, clock, reset, req_accept, !req_chan.ready)
   `PFDE_ASSERT_SAME(no_request_while_response, clock, reset, rsp_chan.valid, !req_chan.ready)
   `PFDE_ASSERT_SAME(data_only_for_read, clock, reset, rsp_chan.valid && (req_ff.operation != OP_READ), rsp_chan.payload.read_data == 8'h00)
   `PFDE_ASSERT_SAME(write_inside_store, clock, reset, mem_we, wr_addr <= LAST_ADDR)

endmodule

@@ bench/testbench.sv @@
module testbench;
   import pfde_pkg::*;

   localparam int WIDTH_PX   = DISPLAY_WIDTH_DEFAULT;
   localparam int HEIGHT_PX  = DISPLAY_HEIGHT_DEFAULT;
   localparam int FRAME_SIZE = WIDTH_PX * ((HEIGHT_PX + 7) / 8);
   localparam int FONT_CODES = 123;
   localparam int RANDOM_REQUESTS = 900;
   localparam int REPORT_LIMIT = 10;

   // Operation codes that the engine treats as no-ops.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // Mirror of the frame store and the font; predicts one response per request.
   class frame_mirror;
      typedef struct {
         logic [2:0]      op;
         rsp_payload_type rsp;
      } pending_entry_type;

      logic [7:0]        frame [0:FRAME_SIZE-1];
      logic [47:0]       font [0:FONT_CODES-1];
      pending_entry_type pending [$];
      int                mismatches;

      function new();
         foreach (frame[i]) frame[i] = 8'h00;
         foreach (font[i]) font[i] = 48'h0;
         mismatches = 0;
         font[8'h2B] = 48'h10107C101000;
         font[8'h2D] = 48'h101010101000;
         font[8'h2E] = 48'h006060000000;
         font[8'h2F] = 48'h201008040200;
         font[8'h30] = 48'h3E5149453E00;
         font[8'h31] = 48'h00427F400000;
         font[8'h32] = 48'h426151494600;
         font[8'h33] = 48'h2141454B3100;
         font[8'h34] = 48'h1814127F1000;
         font[8'h35] = 48'h274545453900;
         font[8'h36] = 48'h3C4A49493000;
         font[8'h37] = 48'h017109050300;
         font[8'h38] = 48'h364949493600;
         font[8'h39] = 48'h064949291E00;
         font[8'h3A] = 48'h003636000000;
         font[8'h3E] = 48'h004122140800;
         font[8'h41] = 48'h7E1111117E00;
         font[8'h42] = 48'h7F4949493600;
         font[8'h43] = 48'h3E4141412200;
         font[8'h44] = 48'h7F4141221C00;
         font[8'h45] = 48'h7F4949494100;
         font[8'h46] = 48'h7F0909090100;
         font[8'h47] = 48'h3E4149497A00;
         font[8'h48] = 48'h7F0808087F00;
         font[8'h49] = 48'h00417F410000;
         font[8'h4A] = 48'h2040413F0100;
         font[8'h4B] = 48'h7F0814224100;
         font[8'h4C] = 48'h7F4040404000;
         font[8'h4D] = 48'h7F020C027F00;
         font[8'h4E] = 48'h7F0408107F00;
         font[8'h4F] = 48'h3E4141413E00;
         font[8'h50] = 48'h7F0909090600;
         font[8'h51] = 48'h3E4151215E00;
         font[8'h52] = 48'h7F0919294600;
         font[8'h53] = 48'h464949493100;
         font[8'h54] = 48'h01017F010100;
         font[8'h55] = 48'h3F4040403F00;
         font[8'h56] = 48'h1F2040201F00;
         font[8'h57] = 48'h3F4038403F00;
         font[8'h58] = 48'h631408146300;
         font[8'h59] = 48'h070870080700;
         font[8'h5A] = 48'h615149454300;
         font[8'h5F] = 48'h404040404000;
         font[8'h61] = 48'h205454547800;
         font[8'h62] = 48'h7F4844443800;
         font[8'h63] = 48'h384444442000;
         font[8'h64] = 48'h384444487F00;
         font[8'h65] = 48'h385454541800;
         font[8'h66] = 48'h087E09010200;
         font[8'h67] = 48'h0C5252523E00;
         font[8'h68] = 48'h7F0804047800;
         font[8'h69] = 48'h00447D400000;
         font[8'h6A] = 48'h2040443D0000;
         font[8'h6B] = 48'h7F1028440000;
         font[8'h6C] = 48'h00417F400000;
         font[8'h6D] = 48'h7C0418047800;
         font[8'h6E] = 48'h7C0804047800;
         font[8'h6F] = 48'h384444443800;
         font[8'h70] = 48'h7C1414140800;
         font[8'h71] = 48'h081414187C00;
         font[8'h72] = 48'h7C0804040800;
         font[8'h73] = 48'h485454542000;
         font[8'h74] = 48'h043F44402000;
         font[8'h75] = 48'h3C4040207C00;
         font[8'h76] = 48'h1C2040201C00;
         font[8'h77] = 48'h3C4030403C00;
         font[8'h78] = 48'h442810284400;
         font[8'h79] = 48'h0C5050503C00;
         font[8'h7A] = 48'h4464544C4400;
      endfunction

      // Returns 0 when the pixel lies off the display and nothing is written.
      function bit plot(int px, int py, bit set);
         int idx;
         if (px >= WIDTH_PX || py >= HEIGHT_PX) return 1'b0;
         idx = (py / 8) * WIDTH_PX + px;
         frame[idx][py % 8] = set;
         return 1'b1;
      endfunction

      function void note_request(req_payload_type r);
         int                x, y, w, h, col, row, k, dx, dy;
         logic [47:0]       pattern;
         bit                on_edge;
         pending_entry_type e;
         x = int'(r.x_pos);
         y = int'(r.y_pos);
         w = int'(r.span_width);
         h = int'(r.span_height);
         e.op = r.operation;
         e.rsp = '0;
         case (r.operation)
            OP_CLEAR: begin
               foreach (frame[i]) frame[i] = 8'h00;
            end
            OP_PIXEL: begin
               e.rsp.ignored = !plot(x, y, r.pixel_on);
            end
            OP_GLYPH: begin
               if (x > WIDTH_PX - GLYPH_COLS || y > HEIGHT_PX - GLYPH_ROWS) begin
                  e.rsp.ignored = 1'b1;
               end else begin
                  pattern = (int'(r.char_code) < FONT_CODES) ? font[r.char_code] : 48'h0;
                  for (col = 0; col < GLYPH_COLS; col++)
                     for (row = 0; row < GLYPH_ROWS; row++)
                        void'(plot((x + col) & 255, (y + row) & 255,
                                   pattern[47 - 8 * col - (7 - row)]));
               end
            end
            OP_LINE: begin
               for (k = 0; k < w; k++) void'(plot((x + k) & 255, y, 1'b1));
            end
            OP_BOX: begin
               for (dy = 0; dy < h; dy++)
                  for (dx = 0; dx < w; dx++) begin
                     on_edge = dx == 0 || dy == 0 || dx == w - 1 || dy == h - 1;
                     if (r.fill_box || on_edge)
                        void'(plot((x + dx) & 255, (y + dy) & 255, 1'b1));
                  end
            end
            OP_READ: begin
               if (int'(r.read_index) < FRAME_SIZE) e.rsp.read_data = frame[r.read_index];
            end
            default: ;
         endcase
         pending.push_back(e);
      endfunction

      function void check_response(rsp_payload_type got);
         pending_entry_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("response with no request outstanding: read_data %02h ignored %b",
                        got.read_data, got.ignored);
            return;
         end
         want = pending.pop_front();
         if (got.read_data !== want.rsp.read_data || got.ignored !== want.rsp.ignored) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("mismatch on op %0d: expected read_data %02h ignored %b, got %02h %b",
                        want.op, want.rsp.read_data, want.rsp.ignored,
                        got.read_data, got.ignored);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   idle_enabled = 1'b1;
   int   last_x = 0;
   int   last_y = 0;

   frame_mirror mirror = new();

   pfde_stream_if #(.payload_type(req_payload_type)) req_if ();
   pfde_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   page_framebuffer_draw_engine i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int roll;
      if (!idle_enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) mirror.note_request(req_if.payload);
         if (rsp_if.valid && rsp_if.ready) mirror.check_response(rsp_if.payload);
      end
   end

   initial begin
      int stall;
      stall = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready = 1'b0;
            stall--;
         end else begin
            rsp_if.ready = 1'b1;
            stall = pick_gap();
         end
      end
   end

   function automatic req_payload_type make_request(logic [2:0] op, int x, int y, bit on,
                                                    int code, int w, int h, bit fill,
                                                    int idx);
      req_payload_type r;
      r.operation   = op;
      r.x_pos       = x[7:0];
      r.y_pos       = y[7:0];
      r.pixel_on    = on;
      r.char_code   = code[7:0];
      r.span_width  = w[7:0];
      r.span_height = h[7:0];
      r.fill_box    = fill;
      r.read_index  = idx[9:0];
      return r;
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int pick, shape, idx;
      r.operation   = OP_READ;
      r.x_pos       = 8'($urandom_range(0, 255));
      r.y_pos       = 8'($urandom_range(0, 255));
      r.pixel_on    = 1'($urandom_range(0, 1));
      r.char_code   = 8'($urandom_range(0, 255));
      r.span_width  = 8'($urandom_range(0, 255));
      r.span_height = 8'($urandom_range(0, 255));
      r.fill_box    = 1'($urandom_range(0, 1));
      r.read_index  = 10'($urandom_range(0, 1023));
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         r.operation = OP_CLEAR;
      end else if (pick < 22) begin
         r.operation = OP_PIXEL;
         if ($urandom_range(0, 99) < 85) begin
            r.x_pos = 8'($urandom_range(0, WIDTH_PX - 1));
            r.y_pos = 8'($urandom_range(0, HEIGHT_PX - 1));
         end
      end else if (pick < 37) begin
         r.operation = OP_GLYPH;
         if ($urandom_range(0, 99) < 80) begin
            r.x_pos = 8'($urandom_range(0, WIDTH_PX - GLYPH_COLS));
            r.y_pos = 8'($urandom_range(0, HEIGHT_PX - GLYPH_ROWS));
         end
         if ($urandom_range(0, 99) < 70) r.char_code = 8'($urandom_range(8'h2B, 8'h7A));
      end else if (pick < 49) begin
         r.operation = OP_LINE;
         if ($urandom_range(0, 99) < 85) r.span_width = 8'($urandom_range(0, 40));
         if ($urandom_range(0, 99) < 80) r.y_pos = 8'($urandom_range(0, HEIGHT_PX - 1));
      end else if (pick < 61) begin
         r.operation = OP_BOX;
         // Keep most boxes small; the engine walks every position of the box.
         shape = $urandom_range(0, 99);
         if (shape < 85) begin
            r.span_width  = 8'($urandom_range(0, 16));
            r.span_height = 8'($urandom_range(0, 16));
         end else if (shape < 93) begin
            r.span_height = 8'($urandom_range(0, 4));
         end else begin
            r.span_width = 8'($urandom_range(0, 4));
         end
         if ($urandom_range(0, 99) < 70) begin
            r.x_pos = 8'($urandom_range(0, WIDTH_PX - 1));
            r.y_pos = 8'($urandom_range(0, HEIGHT_PX - 1));
         end
      end else if (pick < 96) begin
         r.operation = OP_READ;
         // Half of the reads look where something was drawn last.
         if ($urandom_range(0, 1) == 1) begin
            idx = ((last_y % HEIGHT_PX) / 8) * WIDTH_PX + (last_x % WIDTH_PX)
                  + $urandom_range(0, 7);
            r.read_index = idx[9:0];
         end
      end else begin
         r.operation = ($urandom_range(0, 1) == 1) ? OP_SPARE_7 : OP_SPARE_6;
      end
      if (r.operation inside {OP_PIXEL, OP_GLYPH, OP_LINE, OP_BOX}) begin
         last_x = int'(r.x_pos);
         last_y = int'(r.y_pos);
      end
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_request(input req_payload_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_if.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.payload = r;
      req_if.valid   = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   task automatic wait_for_responses();
      req_if.valid = 1'b0;
      while (mirror.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(make_request(OP_READ,    0,   0, 0, 0,     0,   0, 0, 0));
      send_request(make_request(OP_PIXEL,   0,   0, 1, 0,     0,   0, 0, 0));
      send_request(make_request(OP_PIXEL, 127,  63, 1, 0,     0,   0, 0, 0));
      send_request(make_request(OP_PIXEL, 128,   0, 1, 0,     0,   0, 0, 0));
      send_request(make_request(OP_PIXEL,   0,  64, 1, 0,     0,   0, 0, 0));
      send_request(make_request(OP_PIXEL, 255, 255, 0, 0,     0,   0, 0, 0));
      send_request(make_request(OP_READ,    0,   0, 0, 0,     0,   0, 0, 1023));
      send_request(make_request(OP_GLYPH,   0,   0, 0, 8'h41, 0,   0, 0, 0));
      send_request(make_request(OP_READ,    0,   0, 0, 0,     0,   0, 0, 1));
      send_request(make_request(OP_GLYPH, 122,  56, 0, 8'h39, 0,   0, 0, 0));
      send_request(make_request(OP_GLYPH, 123,   0, 0, 8'h30, 0,   0, 0, 0));
      send_request(make_request(OP_GLYPH,   0,  57, 0, 8'h30, 0,   0, 0, 0));
      // Codes without a font entry, and codes past the table, blank the cell.
      send_request(make_request(OP_GLYPH,   0,   0, 0, 8'h7B, 0,   0, 0, 0));
      send_request(make_request(OP_GLYPH, 122,  56, 0, 8'hFF, 0,   0, 0, 0));
      send_request(make_request(OP_LINE,  120,  10, 0, 0,     20,  0, 0, 0));
      send_request(make_request(OP_LINE,  250,  20, 0, 0,     10,  0, 0, 0));
      send_request(make_request(OP_LINE,    5,   5, 0, 0,     0,   0, 0, 0));
      send_request(make_request(OP_LINE,    0,  63, 0, 0,     255, 0, 0, 0));
      send_request(make_request(OP_BOX,    10,  10, 0, 0,     8,   8, 0, 0));
      send_request(make_request(OP_BOX,    30,  30, 0, 0,     5,   3, 1, 0));
      send_request(make_request(OP_BOX,    40,  40, 0, 0,     0,   5, 1, 0));
      send_request(make_request(OP_BOX,    60,  40, 0, 0,     1,   1, 0, 0));
      send_request(make_request(OP_BOX,   250, 250, 0, 0,     12,  12, 1, 0));
      send_request(make_request(OP_SPARE_6, 3,   3, 1, 8'h41, 3,   3, 1, 5));
      send_request(make_request(OP_SPARE_7, 255, 255, 1, 255, 255, 255, 1, 1023));
      send_request(make_request(OP_BOX,     0,   0, 0, 0,     255, 255, 1, 0));
      send_request(make_request(OP_READ,    0,   0, 0, 0,     0,   0, 0, 1023));
      send_request(make_request(OP_CLEAR,   0,   0, 0, 0,     0,   0, 0, 0));

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 300 || n == 700) wait_for_responses();
         idle_enabled = !(n >= 400 && n < 550);
         send_request(random_request());
      end

      // Read a spread of the store back so that bytes of every page are compared at the end.
      for (int i = 0; i < FRAME_SIZE; i += 9)
         send_request(make_request(OP_READ, 0, 0, 0, 0, 0, 0, 0, i));

      wait_for_responses();
      repeat (20) @(negedge clock);
      if (mirror.mismatches == 0 && mirror.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #100000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
